/* src/occupancy_light_command_controller_core_defines.svh */
// Assertion macros for the occupancy light controller
`ifndef OCCUPANCY_LIGHT_COMMAND_CONTROLLER_CORE_DEFINES_SVH
`define OCCUPANCY_LIGHT_COMMAND_CONTROLLER_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define OLC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* src/olcc_pkg.sv */
// Package: types and constants of the occupancy light controller
`timescale 1ns / 1ps
package olcc_pkg;
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_BTN  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  localparam logic [3:0] MSG_NONE    = 4'd0;
  localparam logic [3:0] MSG_DIGIT   = 4'd1;
  localparam logic [3:0] MSG_BX      = 4'd2;
  localparam logic [3:0] MSG_PWM     = 4'd3;
  localparam logic [3:0] MSG_RANGE   = 4'd4;
  localparam logic [3:0] MSG_UNKNOWN = 4'd5;
  localparam logic [3:0] MSG_BX_ERR  = 4'd6;
  localparam logic [3:0] MSG_HIGH    = 4'd7;
  localparam logic [3:0] MSG_LOW     = 4'd8;
  localparam logic [3:0] MSG_OCC     = 4'd9;
  localparam logic [3:0] MSG_IDLE    = 4'd10;
  localparam logic [3:0] MSG_BTN_OCC = 4'd11;
  localparam logic [3:0] MSG_BTN_IDL = 4'd12;
  localparam logic [3:0] MSG_TIMEOUT = 4'd13;

  localparam logic [0:0] CFG_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_IDLE    = 1'd1;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic [6:0] duty;
    logic       duty_set;
    logic [3:0] message;
    logic       occupied;
  } out_word_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == 8'h00) || (c == 8'h0d) || (c == 8'h0a) || is_blank(c);
  endfunction

  function automatic logic [6:0] digit_x10(input logic [7:0] c);
    logic [3:0] d;
    d = c[3:0];
    return {d, 3'b000} - {3'b000, d} - {3'b000, d} + {2'b00, d, 1'b0} +
           {3'b000, d} + {3'b000, d};
  endfunction
endpackage

/* src/olcc_ram.sv */
// Generic single-port-write, one-read RAM with registered read data
`timescale 1ns / 1ps
module olcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* src/occupancy_light_command_controller_core.sv */
// Top level: occupancy light command controller
// Use: drive in_valid/in_word (opcode, char_code); a held word waits while
// in_stall is high. One result word per item appears on out_valid/out_word
// and holds while out_stall is high.
// Sequence: button, tick and single-character items pass from accept to
// result through an execute state and then a done state. A CR/LF ending
// a buffered line walks the line buffer RAM entry by entry (address, then
// registered read), visiting at most LINE_CAPACITY+2 entries.
// Items are worked one at a time; the next is accepted the cycle after the
// result word is taken, so a waiting result stalls the input.
// Configuration: cfg_index 0 timeout_ms, 1 idle_level; write only when idle.
// Reset (rst_n low, synchronous): idle, duty 0, empty line, no pending B,
// quiet time 0, timeout_ms 30000, idle_level 0. No clearing pass needed.
`timescale 1ns / 1ps
`include "occupancy_light_command_controller_core_defines.svh"
module occupancy_light_command_controller_core #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  olcc_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output olcc_pkg::out_word_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  localparam int SLOTS = LINE_CAPACITY - 1;
  localparam int AW = $clog2(SLOTS);
  localparam int FW = $clog2(LINE_CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PWM   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // parse phase inside S_SCAN
  typedef enum logic [3:0] {
    P_BLANK = 4'b0001,
    P_C1    = 4'b0010,
    P_C2    = 4'b0100,
    P_C3    = 4'b1000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  olcc_pkg::in_word_t in_r;
  olcc_pkg::out_word_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic occ_r, occ_nxt;
  logic dexp_r, dexp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [31:0] quiet_r, quiet_nxt;
  logic [6:0] duty_r, duty_nxt;
  logic [31:0] tmo_r;
  logic [6:0] idle_r;
  logic [FW-1:0] pos_r, pos_nxt;
  logic [7:0] c0_r, c0_nxt, c1_r, c1_nxt;
  logic [6:0] acc_r, acc_nxt;
  logic any_r, any_nxt;
  logic pwm_dig_r, pwm_dig_nxt;
  logic rd_pend_r, rd_pend_nxt;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0] rd_data;
  logic [7:0] ch;
  logic [7:0] cur;
  logic [10:0] acc_w;
  logic set;
  logic [3:0] msg;
  logic [6:0] dval;

  olcc_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_line (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_r.char_code),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign cfg_ready = 1'b1;
  assign ch = in_r.char_code;
  assign rd_addr = pos_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_BLANK;
      out_valid_r <= 1'b0;
      occ_r       <= 1'b0;
      dexp_r      <= 1'b0;
      fill_r      <= '0;
      quiet_r     <= '0;
      duty_r      <= '0;
      tmo_r       <= 32'd30000;
      idle_r      <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      occ_r       <= occ_nxt;
      dexp_r      <= dexp_nxt;
      fill_r      <= fill_nxt;
      quiet_r     <= quiet_nxt;
      duty_r      <= duty_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          olcc_pkg::CFG_TIMEOUT: tmo_r <= cfg_data;
          olcc_pkg::CFG_IDLE:    idle_r <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_word;
    out_r     <= out_nxt;
    pos_r     <= pos_nxt;
    c0_r      <= c0_nxt;
    c1_r      <= c1_nxt;
    acc_r     <= acc_nxt;
    any_r     <= any_nxt;
    pwm_dig_r <= pwm_dig_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    occ_nxt = occ_r;
    dexp_nxt = dexp_r;
    fill_nxt = fill_r;
    quiet_nxt = quiet_r;
    duty_nxt = duty_r;
    pos_nxt = pos_r;
    c0_nxt = c0_r;
    c1_nxt = c1_r;
    acc_nxt = acc_r;
    any_nxt = any_r;
    pwm_dig_nxt = pwm_dig_r;
    rd_pend_nxt = 1'b0;
    wr_en = 1'b0;
    wr_addr = fill_r[AW-1:0];
    set = 1'b0;
    msg = olcc_pkg::MSG_NONE;
    dval = duty_r;
    cur = (pos_r < fill_r) ? rd_data : 8'h00;
    acc_w = {4'b0, acc_r} * 11'd10 + {7'b0, cur[3:0]};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (in_r.opcode)
          olcc_pkg::OP_CHAR: begin
            if (dexp_r) begin
              fill_nxt = '0;
              dexp_nxt = 1'b0;
              if (olcc_pkg::is_digit(ch)) begin
                set = 1'b1; dval = olcc_pkg::digit_x10(ch);
                msg = olcc_pkg::MSG_BX; quiet_nxt = '0;
              end else begin
                msg = olcc_pkg::MSG_BX_ERR;
              end
            end else begin
              case (ch)
                8'h68, 8'h48: begin
                  fill_nxt = '0; set = 1'b1; dval = olcc_pkg::DUTY_MAX;
                  msg = olcc_pkg::MSG_HIGH; quiet_nxt = '0;
                end
                8'h6c, 8'h4c: begin
                  fill_nxt = '0; set = 1'b1; dval = '0;
                  msg = olcc_pkg::MSG_LOW; quiet_nxt = '0;
                end
                8'h6f, 8'h4f: begin
                  fill_nxt = '0; set = 1'b1; dval = olcc_pkg::DUTY_MAX;
                  occ_nxt = 1'b1; msg = olcc_pkg::MSG_OCC; quiet_nxt = '0;
                end
                8'h69, 8'h49: begin
                  fill_nxt = '0; set = 1'b1; dval = '0;
                  occ_nxt = 1'b0; msg = olcc_pkg::MSG_IDLE; quiet_nxt = '0;
                end
                8'h62, 8'h42: begin
                  fill_nxt = '0; dexp_nxt = 1'b1;
                end
                default: begin
                  if (fill_r == '0 && olcc_pkg::is_digit(ch)) begin
                    set = 1'b1; dval = olcc_pkg::digit_x10(ch);
                    msg = olcc_pkg::MSG_DIGIT; quiet_nxt = '0;
                  end else if (ch == 8'h0d || ch == 8'h0a) begin
                    if (fill_r != '0) begin
                      state_nxt = S_SCAN;
                      phase_nxt = P_BLANK;
                      pos_nxt = '0;
                    end
                  end else if (fill_r < FW'(SLOTS)) begin
                    wr_en = 1'b1;
                    fill_nxt = fill_r + 1'b1;
                  end else begin
                    fill_nxt = '0;
                  end
                end
              endcase
            end
          end
          olcc_pkg::OP_BTN: begin
            occ_nxt = !occ_r; set = 1'b1; quiet_nxt = '0;
            dval = occ_r ? 7'd0 : olcc_pkg::DUTY_MAX;
            msg = occ_r ? olcc_pkg::MSG_BTN_IDL : olcc_pkg::MSG_BTN_OCC;
          end
          olcc_pkg::OP_TICK: begin
            if (quiet_r != '1) quiet_nxt = quiet_r + 1'b1;
            if (occ_r && quiet_nxt >= tmo_r) begin
              occ_nxt = 1'b0; set = 1'b1;
              dval = (idle_r > olcc_pkg::DUTY_MAX) ? olcc_pkg::DUTY_MAX : idle_r;
              msg = olcc_pkg::MSG_TIMEOUT;
            end
          end
          default: ;
        endcase
        if (state_nxt == S_DONE) begin
          if (set) duty_nxt = dval;
          out_nxt = '{duty: set ? dval : duty_r, duty_set: set, message: msg,
                      occupied: occ_nxt};
        end
      end
      S_SCAN: begin
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          unique case (phase_r)
            P_BLANK: begin
              if (pos_r < fill_r && olcc_pkg::is_blank(cur)) begin
                pos_nxt = pos_r + 1'b1;
              end else begin
                c0_nxt = cur; phase_nxt = P_C1; pos_nxt = pos_r + 1'b1;
              end
            end
            P_C1: begin
              c1_nxt = cur; phase_nxt = P_C2; pos_nxt = pos_r + 1'b1;
            end
            P_C2: begin
              state_nxt = S_DONE;
              if (olcc_pkg::is_digit(c0_r) && olcc_pkg::is_term(c1_r)) begin
                set = 1'b1; dval = olcc_pkg::digit_x10(c0_r);
                msg = olcc_pkg::MSG_DIGIT;
              end else if ((c0_r == 8'h42 || c0_r == 8'h62) &&
                           olcc_pkg::is_digit(c1_r) && olcc_pkg::is_term(cur)) begin
                set = 1'b1; dval = olcc_pkg::digit_x10(c1_r);
                msg = olcc_pkg::MSG_BX;
              end else if ((c0_r == 8'h50 || c0_r == 8'h70) &&
                           (c1_r == 8'h57 || c1_r == 8'h77) &&
                           (cur == 8'h4d || cur == 8'h6d)) begin
                state_nxt = S_PWM;
                phase_nxt = P_C3;
                pos_nxt = pos_r + 1'b1;
                acc_nxt = '0; any_nxt = 1'b0; pwm_dig_nxt = 1'b0;
              end else begin
                msg = olcc_pkg::MSG_UNKNOWN;
              end
              if (state_nxt == S_DONE) begin
                fill_nxt = '0; quiet_nxt = '0;
                if (set) duty_nxt = dval;
                out_nxt = '{duty: set ? dval : duty_r, duty_set: set,
                            message: msg, occupied: occ_r};
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PWM: begin
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else if (pos_r < fill_r && !pwm_dig_r && olcc_pkg::is_blank(cur)) begin
          pos_nxt = pos_r + 1'b1;
        end else if (pos_r < fill_r && olcc_pkg::is_digit(cur)) begin
          pwm_dig_nxt = 1'b1; any_nxt = 1'b1;
          acc_nxt = (acc_w > 11'd100) ? 7'd101 : acc_w[6:0];
          pos_nxt = pos_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
          fill_nxt = '0; quiet_nxt = '0;
          if (any_r && acc_r <= olcc_pkg::DUTY_MAX) begin
            duty_nxt = acc_r;
            out_nxt = '{duty: acc_r, duty_set: 1'b1, message: olcc_pkg::MSG_PWM,
                        occupied: occ_r};
          end else begin
            out_nxt = '{duty: duty_r, duty_set: 1'b0, message: olcc_pkg::MSG_RANGE,
                        occupied: occ_r};
          end
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `OLC_ASSERT(a_no_accept_busy, (state_r != S_IDLE), in_stall, "accept while busy")
  `OLC_ASSERT(a_duty_range, out_valid, (out_word.duty <= olcc_pkg::DUTY_MAX), "duty > 100")
  `OLC_ASSERT(a_fill_range, 1'b1, (fill_r <= FW'(SLOTS)), "line fill overflow")
  `OLC_ASSERT_NXT(a_done_out, (state_r == S_DONE), out_valid, "result lost")
endmodule
